// ===== rtl/tach_pkg.sv =====
// Shared types and constants for the two-channel edge interval tachometer.
// Holds field widths, register indexes, reset values and the sequencer states.
// No dependencies.
package tach_pkg;

  // Field widths
  localparam int unsigned MS_W       = 32;
  localparam int unsigned TICK_W     = 24;
  localparam int unsigned IVL_W      = 32;
  localparam int unsigned SPEED_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUM    = 2'd1;

  // Register reset values
  localparam logic [TICK_W-1:0]  TICKS_PER_MS_RST = 24'd72000;
  localparam logic [SPEED_W-1:0] SPEED_NUM_RST    = 32'd360000000;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPAN,
    ST_SUM,
    ST_MEAN,
    ST_DIV_MEAN,
    ST_CHECK,
    ST_DIV_SPEED,
    ST_DONE
  } tach_state_e;

endpackage

// ===== rtl/two_channel_edge_interval_tachometer.sv =====
// Two-channel edge interval tachometer, top level.
//
// Input channel: one beat per encoder edge (edge_channel_i, ms_time_i,
// tick_value_i) under in_valid_i / in_stall_o. Output channel: one beat per
// edge (sample_stored_o, interval_ticks_o, speed_o, mean_was_zero_o) under
// out_valid_o / out_stall_i. Config channel: cfg_valid_i / cfg_ready_o with
// cfg_index_i (0 ticks_per_ms, 1 speed_numerator, others ignored) and
// cfg_data_i; ready is always high, write only while the block is idle.
//
// One edge at a time: a 32-bit multiply, a sweep over the interval ring
// (one registered read a cycle) and one shared restoring divider that
// retires one quotient bit per cycle over SUM_W = 32 + clog2(SAMPLES)
// bits. With SAMPLES a power of two the mean is a shift; other SAMPLES
// values use the divider for the mean division. A zero mean skips the
// speed division. in_stall_o is high while an edge is in work.
// A stalled result holds in the output register; a finished edge waits
// in the done state only while the previous result is stalled there.
// Reset clears the channel stamps, the ring (per-entry valid bits) and the
// registers to their defaults; the block is ready in the first cycle.
module two_channel_edge_interval_tachometer #(
  parameter int unsigned SAMPLES = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // edge input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            edge_channel_i,
  input  logic [tach_pkg::MS_W-1:0]       ms_time_i,
  input  logic [tach_pkg::TICK_W-1:0]     tick_value_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            sample_stored_o,
  output logic [tach_pkg::IVL_W-1:0]      interval_ticks_o,
  output logic [tach_pkg::SPEED_W-1:0]    speed_o,
  output logic                            mean_was_zero_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tach_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tach_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tach_pkg::*;

  localparam int unsigned IDX_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned CNT_W  = $clog2(SAMPLES + 1);
  localparam int unsigned LOG2_S = $clog2(SAMPLES);
  localparam int unsigned SUM_W  = IVL_W + LOG2_S;
  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);
  localparam bit          POW2   = ((SAMPLES & (SAMPLES - 1)) == 0);

  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(SAMPLES - 1);
  localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(SAMPLES);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(SUM_W - 1);

  tach_state_e state_q, state_d;

  // configuration
  logic [TICK_W-1:0]  ticks_per_ms_q;
  logic [SPEED_W-1:0] speed_num_q;

  // channel stamps
  logic              last_ch_q;
  logic [MS_W-1:0]   ch1_ms_q, ch2_ms_q;
  logic [TICK_W-1:0] ch1_tick_q, ch2_tick_q;

  // per-edge working registers
  logic              stored_q;
  logic [MS_W-1:0]   ms_diff_q;
  logic [TICK_W-1:0] old_tick_q, new_tick_q;
  logic [IVL_W-1:0]  prod_q, interval_q, mean_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  sum_cnt_q;
  logic [SPEED_W-1:0] speed_q;
  logic              zero_q;

  // interval ring
  logic [IVL_W-1:0]   ring_mem [SAMPLES];
  logic [SAMPLES-1:0] ring_vld_q;
  logic [IDX_W-1:0]   widx_q;
  logic [IVL_W-1:0]   rd_data_q;
  logic               rd_vld_q;

  // shared divider
  logic [SUM_W-1:0]  rem_q, quo_q, dvs_q;
  logic [DCNT_W-1:0] div_cnt_q;
  logic [SUM_W:0]    div_shift, div_trial;
  logic [SUM_W-1:0]  div_rem_nx, div_quo_nx;
  logic              div_last;

  // sequencer controls
  logic in_take, rd_en, div_load, div_step, out_load;

  logic              accept;
  logic              alternate;
  logic [IVL_W-1:0]  mult_res, span_res, rd_term;
  logic [SUM_W-1:0]  div_n_sel, div_d_sel;

  assign accept    = in_valid_i && !in_stall_o;
  assign alternate = (edge_channel_i != last_ch_q);
  assign cfg_ready_o = 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_MUL;
      ST_MUL:       state_d = ST_SPAN;
      ST_SPAN:      state_d = ST_SUM;
      ST_SUM:       if (sum_cnt_q == CNT_END) state_d = ST_MEAN;
      ST_MEAN:      state_d = POW2 ? ST_CHECK : ST_DIV_MEAN;
      ST_DIV_MEAN:  if (div_last) state_d = ST_CHECK;
      ST_CHECK:     state_d = (mean_q == '0) ? ST_DONE : ST_DIV_SPEED;
      ST_DIV_SPEED: if (div_last) state_d = ST_DONE;
      ST_DONE:      if (!out_valid_o || !out_stall_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_take  = 1'b0;
    rd_en    = 1'b0;
    div_load = 1'b0;
    div_step = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE:      in_take  = in_valid_i;
      ST_SUM:       rd_en    = (sum_cnt_q != CNT_END);
      ST_MEAN:      div_load = !POW2;
      ST_CHECK:     div_load = (mean_q != '0);
      ST_DIV_MEAN,
      ST_DIV_SPEED: div_step = 1'b1;
      ST_DONE:      out_load = !out_valid_o || !out_stall_i;
      default:      ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_ms_q <= TICKS_PER_MS_RST;
      speed_num_q    <= SPEED_NUM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_TICKS_PER_MS) begin
        ticks_per_ms_q <= cfg_data_i[TICK_W-1:0];
      end else if (cfg_index_i == CFG_SPEED_NUM) begin
        speed_num_q <= cfg_data_i[SPEED_W-1:0];
      end
    end
  end

  // Update channel stamps on each accepted edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ch_q  <= 1'b0;
      ch1_ms_q   <= '0;
      ch1_tick_q <= '0;
      ch2_ms_q   <= '0;
      ch2_tick_q <= '0;
    end else if (accept) begin
      last_ch_q <= edge_channel_i;
      if (!edge_channel_i) begin
        ch1_ms_q   <= ms_time_i;
        ch1_tick_q <= tick_value_i;
      end else begin
        ch2_ms_q   <= ms_time_i;
        ch2_tick_q <= tick_value_i;
      end
    end
  end

  // Interval arithmetic: ms difference, then multiply, then tick correction
  assign mult_res = IVL_W'(ticks_per_ms_q) * ms_diff_q;
  assign span_res = prod_q + IVL_W'(old_tick_q) - IVL_W'(new_tick_q);

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      stored_q   <= alternate;
      ms_diff_q  <= ms_time_i - (edge_channel_i ? ch1_ms_q : ch2_ms_q);
      old_tick_q <= edge_channel_i ? ch1_tick_q : ch2_tick_q;
      new_tick_q <= tick_value_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= mult_res;
    end
    if (state_q == ST_SPAN) begin
      interval_q <= stored_q ? span_res : '0;
    end
  end

  // Ring write index and per-entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q     <= '0;
      ring_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (state_q == ST_SPAN && stored_q) begin
        ring_vld_q[widx_q] <= 1'b1;
        widx_q <= (widx_q == IDX_LAST) ? '0 : widx_q + 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= ring_vld_q[sum_cnt_q[IDX_W-1:0]];
      end
    end
  end

  // Ring storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SPAN && stored_q) begin
      ring_mem[widx_q] <= span_res;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[sum_cnt_q[IDX_W-1:0]];
    end
  end

  // Sweep the ring into the sum, one entry a cycle
  assign rd_term = rd_vld_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SPAN) begin
      sum_cnt_q <= '0;
      sum_q     <= '0;
    end else if (state_q == ST_SUM) begin
      sum_cnt_q <= sum_cnt_q + 1'b1;
      if (sum_cnt_q != '0) begin
        sum_q <= sum_q + SUM_W'(rd_term);
      end
    end
  end

  // Shared restoring divider, one quotient bit a cycle
  assign div_shift  = {rem_q, quo_q[SUM_W-1]};
  assign div_trial  = div_shift - {1'b0, dvs_q};
  assign div_rem_nx = div_trial[SUM_W] ? div_shift[SUM_W-1:0] : div_trial[SUM_W-1:0];
  assign div_quo_nx = {quo_q[SUM_W-2:0], !div_trial[SUM_W]};
  assign div_last   = (div_cnt_q == DIV_LAST);

  assign div_n_sel = (state_q == ST_MEAN) ? sum_q : SUM_W'(speed_num_q);
  assign div_d_sel = (state_q == ST_MEAN) ? SUM_W'(SAMPLES) : SUM_W'(mean_q);

  always_ff @(posedge clk_i) begin
    if (div_load) begin
      rem_q     <= '0;
      quo_q     <= div_n_sel;
      dvs_q     <= div_d_sel;
      div_cnt_q <= '0;
    end else if (div_step) begin
      rem_q     <= div_rem_nx;
      quo_q     <= div_quo_nx;
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // Mean and speed
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MEAN && POW2) begin
      mean_q <= IVL_W'(sum_q >> LOG2_S);
    end else if (state_q == ST_DIV_MEAN && div_last) begin
      mean_q <= div_quo_nx[IVL_W-1:0];
    end
    if (state_q == ST_CHECK && mean_q == '0) begin
      speed_q <= '1;
      zero_q  <= 1'b1;
    end else if (state_q == ST_DIV_SPEED && div_last) begin
      speed_q <= div_quo_nx[SPEED_W-1:0];
      zero_q  <= 1'b0;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_stored_o  <= stored_q;
      interval_ticks_o <= interval_q;
      speed_o          <= speed_q;
      mean_was_zero_o  <= zero_q;
    end
  end

endmodule

// ===== rtl/tach_checker.sv =====
// Port-level checks for the two-channel edge interval tachometer.
// Depends on tach_pkg; bound to the top level at the end of this file.
module tach_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            sample_stored_o,
  input logic [tach_pkg::IVL_W-1:0]      interval_ticks_o,
  input logic [tach_pkg::SPEED_W-1:0]    speed_o,
  input logic                            mean_was_zero_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);
  import tach_pkg::*;

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(speed_o)
      && $stable(interval_ticks_o) && $stable(sample_stored_o)
      && $stable(mean_was_zero_o))
    else $error("stalled output beat changed");

  // Saturated speed goes with the zero-mean flag
  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mean_was_zero_o |-> speed_o == '1)
    else $error("zero mean without saturated speed");

  // No stored sample means no interval
  a_no_ivl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_stored_o |-> interval_ticks_o == '0)
    else $error("interval reported without stored sample");

  // An accepted edge keeps the input stalled while it is worked on
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("input taken while an edge is in work");

  // Config writes never stall
  a_cfg_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write not taken");

endmodule

bind two_channel_edge_interval_tachometer tach_checker u_tach_checker (.*);
